// ===== design/packed_ternary_dot_product_macros.svh =====
// Assertion macros for the packed ternary dot product checker.
// Depends on nothing; included by the checker file only.
`ifndef PACKED_TERNARY_DOT_PRODUCT_MACROS_SVH
`define PACKED_TERNARY_DOT_PRODUCT_MACROS_SVH

// Condition at one edge implies a consequence at the same edge.
`define PTDP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Condition at one edge implies a consequence at the next edge.
`define PTDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/ptdp_pkg.sv =====
// Shared constants and the stage payload type of the packed ternary dot product.
// Used by ptdp_cell, ptdp_acc, the checker and the top level; depends on nothing.
package ptdp_pkg;

    localparam int TRIT_COUNT = 10;
    localparam int WORD_W     = 16;
    localparam int ACT_W      = 8;
    localparam int ACTS_W     = TRIT_COUNT * ACT_W;
    localparam int TDATA_W    = WORD_W + ACTS_W;
    // Ten products of magnitude up to 128 fit in 12 signed bits.
    localparam int PSUM_W     = 12;
    localparam int SUM_W      = 32;

    // Exact divide by three for 16-bit values: (q * 43691) >> 17.
    localparam int DIV3_SHIFT = 17;
    localparam int DIV3_MUL   = 43691;
    localparam int PROD_W     = WORD_W + DIV3_SHIFT;

    // Trit codes; the weight is the code minus one.
    localparam logic [1:0] TRIT_NEG  = 2'd0;
    localparam logic [1:0] TRIT_ZERO = 2'd1;
    localparam logic [1:0] TRIT_POS  = 2'd2;

    // Payload handed from one cell to the next.
    typedef struct packed {
        logic                     last;
        logic [WORD_W-1:0]        quot;
        logic signed [PSUM_W-1:0] psum;
        logic [ACTS_W-1:0]        acts;
    } ptdp_beat_t;

endpackage

// ===== design/packed_ternary_dot_product.sv =====
// Packed ternary dot product: ten base-3 weights per word against ten signed activations.
// A last word's result shows on m_tvalid after the ten cell registers and the output register.
// Throughput: one word per cycle, set by the ten-cell trit chain of one stage per trit.
// While a result waits, words keep draining into the running sum; the input stalls only
// once a last word sits at the end of a full ten-cell chain.
// Reset (aresetn low at a clock edge) empties the chain and clears the running sum to zero.
// Depends on ptdp_pkg, ptdp_cell and ptdp_acc.
module packed_ternary_dot_product (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: packed_word[15:0], act_0[23:16], act_1[31:24], ... act_9[95:88]
    input  logic [ptdp_pkg::TDATA_W-1:0]  s_tdata,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: dot_value[31:0]
    output logic [ptdp_pkg::SUM_W-1:0]    m_tdata
);

    logic                 chain_valid [ptdp_pkg::TRIT_COUNT+1];
    logic                 chain_ready [ptdp_pkg::TRIT_COUNT+1];
    ptdp_pkg::ptdp_beat_t chain_beat  [ptdp_pkg::TRIT_COUNT+1];

    // Head of the chain: the whole word, a zero partial sum and all activations.
    assign chain_valid[0]     = s_tvalid;
    assign s_tready           = chain_ready[0];
    assign chain_beat[0].last = s_tlast;
    assign chain_beat[0].quot = s_tdata[ptdp_pkg::WORD_W-1:0];
    assign chain_beat[0].psum = '0;
    assign chain_beat[0].acts = s_tdata[ptdp_pkg::TDATA_W-1:ptdp_pkg::WORD_W];

    // One cell per trit.
    for (genvar k = 0; k < ptdp_pkg::TRIT_COUNT; k++) begin : g_cell
        ptdp_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[k]),
            .in_beat   (chain_beat[k]),
            .in_ready  (chain_ready[k]),
            .out_valid (chain_valid[k+1]),
            .out_beat  (chain_beat[k+1]),
            .out_ready (chain_ready[k+1])
        );
    end

    // Accumulate finished words and present vector results.
    ptdp_acc u_acc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (chain_valid[ptdp_pkg::TRIT_COUNT]),
        .in_beat  (chain_beat[ptdp_pkg::TRIT_COUNT]),
        .in_ready (chain_ready[ptdp_pkg::TRIT_COUNT]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== design/ptdp_cell.sv =====
// One cell of the trit chain: decodes the lowest trit, adds its product, shifts down.
// Depends on ptdp_pkg.
module ptdp_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  ptdp_pkg::ptdp_beat_t in_beat,
    output logic                 in_ready,
    output logic                 out_valid,
    output ptdp_pkg::ptdp_beat_t out_beat,
    input  logic                 out_ready
);

    logic                        valid_reg;
    ptdp_pkg::ptdp_beat_t        beat_reg;
    ptdp_pkg::ptdp_beat_t        beat_next;
    logic [ptdp_pkg::PROD_W-1:0] prod;
    logic [ptdp_pkg::WORD_W-1:0] quot;
    logic [ptdp_pkg::WORD_W-1:0] rem_full;
    logic [1:0]                  trit;
    logic [ptdp_pkg::ACT_W-1:0]  act;
    logic signed [ptdp_pkg::PSUM_W-1:0] act_ext;

    // The cell takes a new beat whenever its register is empty or being drained.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    // Split off the lowest base-3 digit with a reciprocal multiply.
    always_comb begin
        prod     = ptdp_pkg::PROD_W'(in_beat.quot) * ptdp_pkg::PROD_W'(ptdp_pkg::DIV3_MUL);
        quot     = prod[ptdp_pkg::PROD_W-1:ptdp_pkg::DIV3_SHIFT];
        rem_full = in_beat.quot - (quot + {quot[ptdp_pkg::WORD_W-2:0], 1'b0});
        trit     = rem_full[1:0];
        act      = in_beat.acts[ptdp_pkg::ACT_W-1:0];
        act_ext  = {{(ptdp_pkg::PSUM_W - ptdp_pkg::ACT_W){act[ptdp_pkg::ACT_W-1]}}, act};
    end

    // Add or subtract the paired activation and pass the rest down the chain.
    always_comb begin
        beat_next      = in_beat;
        beat_next.quot = quot;
        beat_next.acts = {{ptdp_pkg::ACT_W{1'b0}},
                          in_beat.acts[ptdp_pkg::ACTS_W-1:ptdp_pkg::ACT_W]};
        unique case (trit)
            ptdp_pkg::TRIT_POS: beat_next.psum = in_beat.psum + act_ext;
            ptdp_pkg::TRIT_NEG: beat_next.psum = in_beat.psum - act_ext;
            default:            beat_next.psum = in_beat.psum;
        endcase
    end

    // Stage register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            beat_reg <= beat_next;
        end
    end

endmodule

// ===== design/ptdp_acc.sv =====
// Accumulator and output register at the end of the trit chain.
// Depends on ptdp_pkg.
module ptdp_acc (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    input  ptdp_pkg::ptdp_beat_t        in_beat,
    output logic                        in_ready,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [ptdp_pkg::SUM_W-1:0]  m_tdata
);

    logic [ptdp_pkg::SUM_W-1:0] running_sum_reg;
    logic [ptdp_pkg::SUM_W-1:0] sum_next;
    logic [ptdp_pkg::SUM_W-1:0] dot_reg;
    logic                       out_valid_reg;
    logic                       take;

    // A beat that is not last never needs the output register.
    assign in_ready = !in_beat.last || !out_valid_reg || m_tready;
    assign take     = in_valid && in_ready;
    assign sum_next = running_sum_reg
                    + {{(ptdp_pkg::SUM_W - ptdp_pkg::PSUM_W){in_beat.psum[ptdp_pkg::PSUM_W-1]}},
                       in_beat.psum};

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = dot_reg;

    // Running sum; it clears once the last word of a vector is folded in.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_sum_reg <= '0;
        end else if (take) begin
            running_sum_reg <= in_beat.last ? '0 : sum_next;
        end
    end

    // Output register holding one finished dot product until its transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (take && in_beat.last) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (take && in_beat.last) begin
            dot_reg <= sum_next;
        end
    end

endmodule

// ===== design/ptdp_checker.sv =====
// Port-level checks for the packed ternary dot product, bound to the top level.
// Depends on ptdp_pkg and packed_ternary_dot_product_macros.svh.
`include "packed_ternary_dot_product_macros.svh"

module ptdp_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [ptdp_pkg::SUM_W-1:0]   m_tdata
);

    // A result that is not taken stays put.
    `PTDP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // With the output register empty the chain drains, so the input side is open.
    `PTDP_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready)

    // Leaving reset, no result is pending.
    `PTDP_ASSERT_NOW(a_reset_clears, aclk, aresetn, $rose(aresetn), !m_tvalid)

endmodule

bind packed_ternary_dot_product ptdp_checker u_ptdp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
